FILE: sv/cubic_bezier_classifier_assert.svh
// Assertion macros for the cubic Bezier classifier.
// Included by the top level; needs no package.
`ifndef CUBIC_BEZIER_CLASSIFIER_ASSERT_SVH
`define CUBIC_BEZIER_CLASSIFIER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CBC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cubic_bezier_classifier: same-cycle check failed");
`define CBC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cubic_bezier_classifier: next-cycle check failed");
`else
`define CBC_ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define CBC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/cbc_pkg.sv
// Shared types, constants and step functions for the cubic Bezier classifier.
// No dependencies.
`default_nettype none
package cbc_pkg;

	localparam int RAD_W = 64;
	localparam int ROOT_W = 32;
	localparam int QUO_W = 31;
	localparam int NUM_W = 62;
	localparam int STEPS_PER_STAGE = 2;
	localparam int ROOT_STAGES = ROOT_W / STEPS_PER_STAGE;
	localparam int DIV_STAGES = (QUO_W + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_ZERO_TOL = 1'b0;
	localparam cfg_idx_t CFG_POINT_TOL = 1'b1;

	typedef enum logic [2:0] {
		CT_SERPENTINE = 3'd0,
		CT_SELFCROSS = 3'd1,
		CT_CUSP = 3'd2,
		CT_QUADRATIC = 3'd3,
		CT_LINE = 3'd4,
		CT_POINT = 3'd5
	} curve_type_t;

	typedef struct packed {
		logic [RAD_W-1:0] rad;
		logic [RAD_W-1:0] res;
	} sqrt_st_t;

	typedef struct packed {
		logic [ROOT_W-1:0] rem;
		logic [QUO_W-1:0] nlow;
		logic [QUO_W-1:0] quo;
		logic [ROOT_W-1:0] den;
	} div_st_t;

	function automatic sqrt_st_t sqrt_step(input sqrt_st_t st, input logic [RAD_W-1:0] bw);
		sqrt_st_t o;
		logic [RAD_W:0] t;
		t = {1'b0, st.res} + {1'b0, bw};
		if ({1'b0, st.rad} >= t) begin
			o.rad = st.rad - t[RAD_W-1:0];
			o.res = (st.res >> 1) + bw;
		end else begin
			o.rad = st.rad;
			o.res = st.res >> 1;
		end
		return o;
	endfunction

	function automatic div_st_t div_step(input div_st_t st);
		div_st_t o;
		logic [ROOT_W:0] t;
		logic [ROOT_W:0] df;
		t = {st.rem, st.nlow[QUO_W-1]};
		df = t - {1'b0, st.den};
		o = st;
		o.nlow = {st.nlow[QUO_W-2:0], 1'b0};
		if (t >= {1'b0, st.den}) begin
			o.rem = df[ROOT_W-1:0];
			o.quo = {st.quo[QUO_W-2:0], 1'b1};
		end else begin
			o.rem = t[ROOT_W-1:0];
			o.quo = {st.quo[QUO_W-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage
`default_nettype wire

FILE: sv/cbc_isqrt.sv
// Pipelined integer square root, two result bits per stage.
// Depends on cbc_pkg.
`default_nettype none
module cbc_isqrt (
	input logic clk,
	input logic en,
	input logic [cbc_pkg::RAD_W-1:0] rad,
	output logic [cbc_pkg::ROOT_W-1:0] root
);

	cbc_pkg::sqrt_st_t st_s [cbc_pkg::ROOT_STAGES];

	for (genvar k = 0; k < cbc_pkg::ROOT_STAGES; k++) begin : g_stage
		cbc_pkg::sqrt_st_t src;
		cbc_pkg::sqrt_st_t nxt;
		if (k == 0) begin : g_first
			assign src = '{rad: rad, res: '0};
		end else begin : g_rest
			assign src = st_s[k-1];
		end
		always_comb begin
			nxt = src;
			for (int j = 0; j < cbc_pkg::STEPS_PER_STAGE; j++) begin
				nxt = cbc_pkg::sqrt_step(nxt,
					64'd1 << (62 - 2 * (k * cbc_pkg::STEPS_PER_STAGE + j)));
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign root = st_s[cbc_pkg::ROOT_STAGES-1].res[cbc_pkg::ROOT_W-1:0];

endmodule
`default_nettype wire

FILE: sv/cbc_divider.sv
// Pipelined restoring divider, two quotient bits per stage.
// Depends on cbc_pkg.
`default_nettype none
module cbc_divider (
	input logic clk,
	input logic en,
	input logic [cbc_pkg::NUM_W-1:0] num,
	input logic [cbc_pkg::ROOT_W-1:0] den,
	output logic [cbc_pkg::QUO_W-1:0] quo
);

	cbc_pkg::div_st_t st_s [cbc_pkg::DIV_STAGES];

	for (genvar k = 0; k < cbc_pkg::DIV_STAGES; k++) begin : g_stage
		cbc_pkg::div_st_t src;
		cbc_pkg::div_st_t nxt;
		if (k == 0) begin : g_first
			assign src = '{rem: {1'b0, num[cbc_pkg::NUM_W-1:cbc_pkg::QUO_W]},
				nlow: num[cbc_pkg::QUO_W-1:0], quo: '0, den: den};
		end else begin : g_rest
			assign src = st_s[k-1];
		end
		always_comb begin
			nxt = src;
			for (int j = 0; j < cbc_pkg::STEPS_PER_STAGE; j++) begin
				if (k * cbc_pkg::STEPS_PER_STAGE + j < cbc_pkg::QUO_W) begin
					nxt = cbc_pkg::div_step(nxt);
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k] <= nxt;
			end
		end
	end

	assign quo = st_s[cbc_pkg::DIV_STAGES-1].quo;

endmodule
`default_nettype wire

FILE: sv/cubic_bezier_classifier.sv
// Cubic Bezier segment classifier: top level pipeline.
// Depends on cbc_pkg, cbc_isqrt, cbc_divider and cubic_bezier_classifier_assert.svh.
//
// Usage:
//   seg channel: the four control points, one item per accepted valid/!stall edge.
//   cls channel: curve_type and normalized d1..d3, one item per segment, in order.
//   cfg channel: cfg_index 0 writes zero_tolerance (cfg_data[14:0]), index 1 writes
//   point_tolerance; cfg_ready is always high. Write only while the pipeline is empty.
// Throughput: one segment per cycle while no result is held back by cls_stall.
//   The depth is set by the 16-stage square root and the 16-stage divider, each
//   resolving two bits per stage.
// Stall: while a result waits with cls_stall high, the whole pipeline holds and
//   seg_stall is high; nothing is lost or repeated.
// Reset: all valid bits clear, zero_tolerance = 16, point_tolerance = 0.
`default_nettype none
`include "cubic_bezier_classifier_assert.svh"
module cubic_bezier_classifier #(
	parameter int COORD_WIDTH = 16,
	parameter int OUT_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input cbc_pkg::cfg_idx_t cfg_index,
	input logic [15:0] cfg_data,
	input logic seg_valid,
	output logic seg_stall,
	input logic signed [COORD_WIDTH-1:0] p0_x,
	input logic signed [COORD_WIDTH-1:0] p0_y,
	input logic signed [COORD_WIDTH-1:0] p1_x,
	input logic signed [COORD_WIDTH-1:0] p1_y,
	input logic signed [COORD_WIDTH-1:0] p2_x,
	input logic signed [COORD_WIDTH-1:0] p2_y,
	input logic signed [COORD_WIDTH-1:0] p3_x,
	input logic signed [COORD_WIDTH-1:0] p3_y,
	output logic cls_valid,
	input logic cls_stall,
	output logic [2:0] curve_type,
	output logic signed [OUT_WIDTH-1:0] norm_d1,
	output logic signed [OUT_WIDTH-1:0] norm_d2,
	output logic signed [OUT_WIDTH-1:0] norm_d3
);

	localparam int SH = (COORD_WIDTH > 28) ? COORD_WIDTH - 28 : 0;
	localparam int DW = COORD_WIDTH + 1 - SH;
	localparam int PW = 2 * DW;
	localparam int AW = PW + 1;
	localparam int DDW = AW + 3;
	localparam int NG = (DDW + 7) / 8;
	localparam int PSW = $clog2(NG * 8);
	localparam int CMW = (COORD_WIDTH + 1 > 16) ? COORD_WIDTH + 1 : 16;
	localparam int NW = cbc_pkg::QUO_W;
	localparam int LAT = 11 + cbc_pkg::ROOT_STAGES + 1 + cbc_pkg::DIV_STAGES + 8;
	localparam int OF = OUT_WIDTH - 1;
	localparam int OSH_R = (OF <= 30) ? 30 - OF : 0;
	localparam int OSH_L = (OF > 30) ? OF - 30 : 0;
	localparam logic [63:0] HALF = (64'd1 << OSH_R) >> 1;
	localparam logic [63:0] POS_MAX = (64'd1 << OF) - 64'd1;
	localparam logic [63:0] NEG_MAX = 64'd1 << OF;

	typedef struct packed {
		logic coin;
		logic zero;
		logic [2:0] sgn;
	} flags_t;

	typedef struct packed {
		flags_t fl;
		logic [2:0][NW-1:0] mn;
	} rt_side_t;

	typedef struct packed {
		flags_t fl;
		logic tneg;
		logic [2:0][NW-1:0] um;
	} tail_t;

	function automatic logic signed [DW-1:0] dsub(input logic signed [COORD_WIDTH-1:0] a,
		input logic signed [COORD_WIDTH-1:0] b);
		logic signed [COORD_WIDTH:0] df;
		logic [COORD_WIDTH:0] mg;
		logic [COORD_WIDTH:0] ms;
		logic [DW-1:0] r;
		df = (COORD_WIDTH + 1)'(a) - (COORD_WIDTH + 1)'(b);
		mg = df[COORD_WIDTH] ? -df : df;
		ms = mg >> SH;
		r = ms[DW-1:0];
		return df[COORD_WIDTH] ? $signed(-r) : $signed(r);
	endfunction

	function automatic logic [CMW-1:0] cmag(input logic signed [COORD_WIDTH-1:0] a,
		input logic signed [COORD_WIDTH-1:0] b);
		logic signed [COORD_WIDTH:0] df;
		logic [COORD_WIDTH:0] mg;
		df = (COORD_WIDTH + 1)'(a) - (COORD_WIDTH + 1)'(b);
		mg = df[COORD_WIDTH] ? -df : df;
		return CMW'(mg);
	endfunction

	function automatic logic [OUT_WIDTH-1:0] to_out(input logic [NW-1:0] um, input logic neg);
		logic [63:0] m;
		m = ((64'(um) + HALF) >> OSH_R) << OSH_L;
		if (!neg) begin
			if (m > POS_MAX) m = POS_MAX;
			return m[OUT_WIDTH-1:0];
		end
		if (m > NEG_MAX) m = NEG_MAX;
		return OUT_WIDTH'((64'd1 << OUT_WIDTH) - m);
	endfunction

	logic [14:0] zero_tol_q;
	logic [15:0] point_tol_q;
	logic adv;
	logic [LAT:1] vld_s;
	logic [29:0] thr;

	logic signed [COORD_WIDTH-1:0] pt_s1 [8];
	logic signed [DW-1:0] df_s2 [12];
	logic signed [PW-1:0] pr_s3 [6];
	logic signed [AW-1:0] a_s4 [3];
	logic signed [DDW-1:0] d_s5 [3];
	logic [2:0][DDW-1:0] mag_s6, mag_s7, mag_s8;
	logic [NG-1:0] gnz_s7;
	logic [NG-1:0][2:0] gpos_s7;
	logic [PSW-1:0] pos_s8;
	logic [2:0][NW-1:0] mn_s9, mn_s10, mn_s11;
	logic [2:0][61:0] sq_s10;
	logic [63:0] sum_s11;
	flags_t fl_s2, fl_s3, fl_s4, fl_s5, fl_s6, fl_s7, fl_s8, fl_s9, fl_s10, fl_s11;
	rt_side_t rt_side_s [cbc_pkg::ROOT_STAGES];
	logic [cbc_pkg::ROOT_W-1:0] root;
	logic [2:0][cbc_pkg::NUM_W-1:0] num_s28;
	logic [cbc_pkg::ROOT_W-1:0] den_s28;
	flags_t fl_s28;
	flags_t dv_fl_s [cbc_pkg::DIV_STAGES];
	logic [2:0][NW-1:0] quo;
	logic signed [31:0] us_s45 [3];
	tail_t tl_s45, tl_s46, tl_s47, tl_s48, tl_s49, tl_s50, tl_s51;
	logic signed [63:0] pa_s46, pb_s46, pc_s46;
	logic [NW-1:0] sq2_s47, sq1_s47, sq1_s48, sq1_s49;
	logic signed [31:0] tr_s47;
	logic signed [33:0] term0_s48;
	logic [32:0] tmag_s49;
	logic [63:0] dprod_s50;
	logic dz_s51;
	logic [2:0] uz_s51;
	cbc_pkg::curve_type_t ct_s52;
	logic [2:0][OUT_WIDTH-1:0] nd_s52;

	logic signed [COORD_WIDTH-1:0] pin [8];
	logic signed [DW-1:0] df_n [12];
	logic coin_n;
	logic [NG*8-1:0] orx;
	logic [NG-1:0] gnz_n;
	logic [NG-1:0][2:0] gpos_n;
	logic [PSW-1:0] pos_n;
	logic [2:0][NW-1:0] mn_n;
	logic [63:0] bmag;
	logic [33:0] dmag;
	cbc_pkg::curve_type_t ct_n;
	logic flat_cls, line_cls, point_cls;

	assign adv = !(vld_s[LAT] && cls_stall);
	assign seg_stall = vld_s[LAT] && cls_stall;
	assign cfg_ready = 1'b1;
	assign thr = {zero_tol_q, 15'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_tol_q <= 15'd16;
			point_tol_q <= 16'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				cbc_pkg::CFG_ZERO_TOL: zero_tol_q <= cfg_data[14:0];
				cbc_pkg::CFG_POINT_TOL: point_tol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-1:1], seg_valid};
		end
	end

	assign pin = '{p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y};

	// point pairs per determinant: (q - p, r - p) for (p,q,r) = (0,3,2), (1,0,3), (2,1,0)
	always_comb begin
		df_n[0] = dsub(pt_s1[6], pt_s1[0]);
		df_n[1] = dsub(pt_s1[7], pt_s1[1]);
		df_n[2] = dsub(pt_s1[4], pt_s1[0]);
		df_n[3] = dsub(pt_s1[5], pt_s1[1]);
		df_n[4] = dsub(pt_s1[0], pt_s1[2]);
		df_n[5] = dsub(pt_s1[1], pt_s1[3]);
		df_n[6] = dsub(pt_s1[6], pt_s1[2]);
		df_n[7] = dsub(pt_s1[7], pt_s1[3]);
		df_n[8] = dsub(pt_s1[2], pt_s1[4]);
		df_n[9] = dsub(pt_s1[3], pt_s1[5]);
		df_n[10] = dsub(pt_s1[0], pt_s1[4]);
		df_n[11] = dsub(pt_s1[1], pt_s1[5]);
		coin_n = 1'b1;
		for (int i = 1; i < 4; i++) begin
			if (cmag(pt_s1[2*i], pt_s1[0]) > CMW'(point_tol_q) ||
				cmag(pt_s1[2*i+1], pt_s1[1]) > CMW'(point_tol_q)) begin
				coin_n = 1'b0;
			end
		end
	end

	always_comb begin
		orx = (NG * 8)'(mag_s6[0] | mag_s6[1] | mag_s6[2]);
		for (int g = 0; g < NG; g++) begin
			gnz_n[g] = |orx[8*g +: 8];
			gpos_n[g] = 3'd0;
			for (int b = 0; b < 8; b++) begin
				if (orx[8*g+b]) gpos_n[g] = 3'(b);
			end
		end
	end

	always_comb begin
		pos_n = '0;
		for (int g = 0; g < NG; g++) begin
			if (gnz_s7[g]) pos_n = PSW'(g * 8) + PSW'(gpos_s7[g]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (int'(pos_s8) >= 30) begin
				mn_n[i] = NW'(64'(mag_s8[i]) >> (int'(pos_s8) - 30));
			end else begin
				mn_n[i] = NW'(64'(mag_s8[i]) << (30 - int'(pos_s8)));
			end
		end
	end

	always_comb begin
		bmag = pb_s46[63] ? -pb_s46 : pb_s46;
		dmag = dprod_s50[63:30];
	end

	always_comb begin
		if (tl_s51.fl.coin) begin
			ct_n = cbc_pkg::CT_POINT;
		end else if (dz_s51) begin
			if (uz_s51[0] && uz_s51[1]) begin
				ct_n = uz_s51[2] ? cbc_pkg::CT_LINE : cbc_pkg::CT_QUADRATIC;
			end else if (uz_s51[0]) begin
				ct_n = cbc_pkg::CT_CUSP;
			end else begin
				ct_n = tl_s51.tneg ? cbc_pkg::CT_SELFCROSS : cbc_pkg::CT_SERPENTINE;
			end
		end else begin
			ct_n = tl_s51.tneg ? cbc_pkg::CT_SELFCROSS : cbc_pkg::CT_SERPENTINE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s1 <= pin;

			df_s2 <= df_n;
			fl_s2 <= '{coin: coin_n, zero: 1'b0, sgn: 3'd0};

			for (int n = 0; n < 3; n++) begin
				pr_s3[2*n] <= df_s2[4*n] * df_s2[4*n+3];
				pr_s3[2*n+1] <= df_s2[4*n+1] * df_s2[4*n+2];
			end
			fl_s3 <= fl_s2;

			for (int n = 0; n < 3; n++) begin
				a_s4[n] <= AW'(pr_s3[2*n]) - AW'(pr_s3[2*n+1]);
			end
			fl_s4 <= fl_s3;

			d_s5[0] <= DDW'(a_s4[0]) - (DDW'(a_s4[1]) <<< 1) + (DDW'(a_s4[2]) <<< 1)
				+ DDW'(a_s4[2]);
			d_s5[1] <= (DDW'(a_s4[2]) <<< 1) + DDW'(a_s4[2]) - DDW'(a_s4[1]);
			d_s5[2] <= (DDW'(a_s4[2]) <<< 1) + DDW'(a_s4[2]);
			fl_s5 <= fl_s4;

			for (int i = 0; i < 3; i++) begin
				mag_s6[i] <= d_s5[i][DDW-1] ? DDW'(-d_s5[i]) : DDW'(d_s5[i]);
			end
			fl_s6 <= '{coin: fl_s5.coin, zero: 1'b0,
				sgn: {d_s5[2][DDW-1], d_s5[1][DDW-1], d_s5[0][DDW-1]}};

			gnz_s7 <= gnz_n;
			gpos_s7 <= gpos_n;
			mag_s7 <= mag_s6;
			fl_s7 <= '{coin: fl_s6.coin, zero: ~|orx, sgn: fl_s6.sgn};

			pos_s8 <= pos_n;
			mag_s8 <= mag_s7;
			fl_s8 <= fl_s7;

			mn_s9 <= mn_n;
			fl_s9 <= fl_s8;

			for (int i = 0; i < 3; i++) begin
				sq_s10[i] <= 62'(mn_s9[i]) * 62'(mn_s9[i]);
			end
			mn_s10 <= mn_s9;
			fl_s10 <= fl_s9;

			sum_s11 <= 64'(sq_s10[0]) + 64'(sq_s10[1]) + 64'(sq_s10[2]);
			mn_s11 <= mn_s10;
			fl_s11 <= fl_s10;

			rt_side_s[0] <= '{fl: fl_s11, mn: mn_s11};
			for (int k = 1; k < cbc_pkg::ROOT_STAGES; k++) begin
				rt_side_s[k] <= rt_side_s[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				num_s28[i] <= {1'b0, rt_side_s[cbc_pkg::ROOT_STAGES-1].mn[i], 30'd0}
					+ {31'd0, root[cbc_pkg::ROOT_W-1:1]};
			end
			den_s28 <= root;
			fl_s28 <= rt_side_s[cbc_pkg::ROOT_STAGES-1].fl;

			dv_fl_s[0] <= fl_s28;
			for (int k = 1; k < cbc_pkg::DIV_STAGES; k++) begin
				dv_fl_s[k] <= dv_fl_s[k-1];
			end

			for (int i = 0; i < 3; i++) begin
				tl_s45.um[i] <= dv_fl_s[cbc_pkg::DIV_STAGES-1].zero ? '0 : quo[i];
				if (dv_fl_s[cbc_pkg::DIV_STAGES-1].zero) begin
					us_s45[i] <= '0;
				end else if (dv_fl_s[cbc_pkg::DIV_STAGES-1].sgn[i]) begin
					us_s45[i] <= -$signed({1'b0, quo[i]});
				end else begin
					us_s45[i] <= $signed({1'b0, quo[i]});
				end
			end
			tl_s45.fl <= dv_fl_s[cbc_pkg::DIV_STAGES-1];
			tl_s45.tneg <= 1'b0;

			pa_s46 <= us_s45[1] * us_s45[1];
			pb_s46 <= us_s45[0] * us_s45[2];
			pc_s46 <= us_s45[0] * us_s45[0];
			tl_s46 <= tl_s45;

			sq2_s47 <= pa_s46[60:30];
			sq1_s47 <= pc_s46[60:30];
			tr_s47 <= pb_s46[63] ? -$signed({1'b0, bmag[60:30]})
				: $signed({1'b0, bmag[60:30]});
			tl_s47 <= tl_s46;

			term0_s48 <= $signed({3'd0, sq2_s47}) + $signed({2'd0, sq2_s47, 1'b0})
				- (34'(tr_s47) <<< 2);
			sq1_s48 <= sq1_s47;
			tl_s48 <= tl_s47;

			tmag_s49 <= term0_s48[33] ? 33'(-term0_s48) : 33'(term0_s48);
			sq1_s49 <= sq1_s48;
			tl_s49 <= '{fl: tl_s48.fl, tneg: term0_s48[33], um: tl_s48.um};

			dprod_s50 <= 64'(sq1_s49) * 64'(tmag_s49);
			tl_s50 <= tl_s49;

			dz_s51 <= (dmag == '0) || (dmag < 34'(thr));
			for (int i = 0; i < 3; i++) begin
				uz_s51[i] <= (tl_s50.um[i] == '0) || (tl_s50.um[i] < NW'(thr));
			end
			tl_s51 <= tl_s50;

			ct_s52 <= ct_n;
			for (int i = 0; i < 3; i++) begin
				nd_s52[i] <= uz_s51[i] ? '0 : to_out(tl_s51.um[i], tl_s51.fl.sgn[i]);
			end
		end
	end

	cbc_isqrt u_isqrt (
		.clk(clk),
		.en(adv),
		.rad(sum_s11),
		.root(root)
	);

	for (genvar i = 0; i < 3; i++) begin : g_div
		cbc_divider u_div (
			.clk(clk),
			.en(adv),
			.num(num_s28[i]),
			.den(den_s28),
			.quo(quo[i])
		);
	end

	assign cls_valid = vld_s[LAT];
	assign curve_type = ct_s52;
	assign norm_d1 = $signed(nd_s52[0]);
	assign norm_d2 = $signed(nd_s52[1]);
	assign norm_d3 = $signed(nd_s52[2]);

	assign flat_cls = (curve_type == cbc_pkg::CT_CUSP) || (curve_type == cbc_pkg::CT_QUADRATIC)
		|| (curve_type == cbc_pkg::CT_LINE);
	assign line_cls = curve_type == cbc_pkg::CT_LINE;
	assign point_cls = curve_type == cbc_pkg::CT_POINT;

	`CBC_ASSERT_IMPLIES(a_flat_class_no_d1, clk, arst_n, cls_valid && flat_cls, norm_d1 == '0)
	`CBC_ASSERT_IMPLIES(a_line_all_zero, clk, arst_n, cls_valid && line_cls, norm_d2 == '0 && norm_d3 == '0)
	`CBC_ASSERT_NEXT(a_stall_holds_class, clk, arst_n, cls_valid && cls_stall && point_cls, point_cls)

endmodule
`default_nettype wire

FILE: dv/cubic_bezier_classifier_tb.sv
// Self-checking testbench for cubic_bezier_classifier: predicts class and normalized d values.
// Depends on cbc_pkg and the classifier RTL; directed, tolerance and random segment tests.
`timescale 1ns / 100ps
module cubic_bezier_classifier_tb;

	typedef logic signed [15:0] coord_t;
	typedef struct {
		cbc_pkg::curve_type_t kind;
		logic signed [15:0] d1;
		logic signed [15:0] d2;
		logic signed [15:0] d3;
	} cls_item_t;

	localparam int LATENCY = 52;
	localparam longint CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cbc_pkg::cfg_idx_t cfg_index = cbc_pkg::CFG_ZERO_TOL;
	logic [15:0] cfg_data = '0;
	logic seg_valid = 1'b0;
	logic seg_stall;
	coord_t p0_x = '0, p0_y = '0, p1_x = '0, p1_y = '0;
	coord_t p2_x = '0, p2_y = '0, p3_x = '0, p3_y = '0;
	logic cls_valid;
	logic cls_stall = 1'b0;
	logic [2:0] curve_type;
	logic signed [15:0] norm_d1, norm_d2, norm_d3;

	cls_item_t pending_cls[$];
	longint unsigned zero_tol = 16;
	longint unsigned point_tol = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;
	longint cycle_count = 0;

	cubic_bezier_classifier u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.seg_valid(seg_valid), .seg_stall(seg_stall),
		.p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y),
		.p2_x(p2_x), .p2_y(p2_y), .p3_x(p3_x), .p3_y(p3_y),
		.cls_valid(cls_valid), .cls_stall(cls_stall), .curve_type(curve_type),
		.norm_d1(norm_d1), .norm_d2(norm_d2), .norm_d3(norm_d3)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		cls_stall <= (int'($urandom_range(99)) < recv_idle_pct);
	end

	function automatic longint unsigned mag(input longint x);
		return x < 0 ? longint'(0) - x : x;
	endfunction

	function automatic longint shr_trunc(input longint x, input int s);
		longint unsigned m;
		m = mag(x) >> s;
		return x < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned res, bw;
		res = 0;
		bw = 64'd1 << 62;
		while (bw > s)
			bw >>= 2;
		while (bw != 0) begin
			if (s >= res + bw) begin
				s -= res + bw;
				res = (res >> 1) + bw;
			end else begin
				res >>= 1;
			end
			bw >>= 2;
		end
		return res;
	endfunction

	function automatic longint det3(input longint px, py, qx, qy, rx, ry);
		return (qx - px) * (ry - py) - (qy - py) * (rx - px);
	endfunction

	function automatic longint clip_tol(input longint x);
		return mag(x) < (zero_tol << 15) ? 0 : x;
	endfunction

	function automatic logic [15:0] to_q15(input longint u);
		longint unsigned m;
		m = (mag(u) + (64'd1 << 14)) >> 15;
		if (u >= 0)
			return (m > 32767) ? 16'h7fff : m[15:0];
		if (m > 32768)
			m = 32768;
		return 16'(65536 - m);
	endfunction

	function automatic cls_item_t classify_segment(input coord_t c[8]);
		cls_item_t r;
		longint px[4], py[4];
		longint a1, a2, a3, term0, discr, sq1, sq2;
		longint d[3], u[3];
		longint unsigned m[3], mx, s, root, q;
		bit coincident;
		for (int i = 0; i < 4; i++) begin
			px[i] = c[2 * i];
			py[i] = c[2 * i + 1];
		end
		a1 = det3(px[0], py[0], px[3], py[3], px[2], py[2]);
		a2 = det3(px[1], py[1], px[0], py[0], px[3], py[3]);
		a3 = det3(px[2], py[2], px[1], py[1], px[0], py[0]);
		d[0] = a1 - 2 * a2 + 3 * a3;
		d[1] = -a2 + 3 * a3;
		d[2] = 3 * a3;
		mx = 0;
		for (int i = 0; i < 3; i++) begin
			m[i] = mag(d[i]);
			u[i] = 0;
			if (m[i] > mx)
				mx = m[i];
		end
		if (mx != 0) begin
			while (mx >= (64'd1 << 31)) begin
				mx >>= 1;
				for (int i = 0; i < 3; i++)
					m[i] >>= 1;
			end
			while (mx < (64'd1 << 30)) begin
				mx <<= 1;
				for (int i = 0; i < 3; i++)
					m[i] <<= 1;
			end
			s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
			root = int_sqrt(s);
			for (int i = 0; i < 3; i++) begin
				q = ((m[i] << 30) + (root >> 1)) / root;
				u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
			end
		end
		sq2 = (u[1] * u[1]) >>> 30;
		sq1 = (u[0] * u[0]) >>> 30;
		term0 = 3 * sq2 - 4 * shr_trunc(u[0] * u[2], 30);
		discr = clip_tol(shr_trunc(sq1 * term0, 30));
		for (int i = 0; i < 3; i++)
			u[i] = clip_tol(u[i]);
		coincident = 1'b1;
		for (int i = 1; i < 4; i++)
			if (mag(px[i] - px[0]) > point_tol || mag(py[i] - py[0]) > point_tol)
				coincident = 1'b0;
		if (coincident)
			r.kind = cbc_pkg::CT_POINT;
		else if (discr == 0) begin
			if (u[0] == 0 && u[1] == 0)
				r.kind = (u[2] == 0) ? cbc_pkg::CT_LINE : cbc_pkg::CT_QUADRATIC;
			else if (u[0] == 0)
				r.kind = cbc_pkg::CT_CUSP;
			else
				r.kind = term0 < 0 ? cbc_pkg::CT_SELFCROSS : cbc_pkg::CT_SERPENTINE;
		end else begin
			r.kind = discr > 0 ? cbc_pkg::CT_SERPENTINE : cbc_pkg::CT_SELFCROSS;
		end
		r.d1 = to_q15(u[0]);
		r.d2 = to_q15(u[1]);
		r.d3 = to_q15(u[2]);
		return r;
	endfunction

	always @(posedge clk) begin
		cls_item_t e;
		if (arst_n && cls_valid && !cls_stall) begin
			if (pending_cls.size() == 0) begin
				$display("%0t: unexpected item type=%0d d=%0d,%0d,%0d", $time, curve_type,
					norm_d1, norm_d2, norm_d3);
				fail_count++;
			end else begin
				e = pending_cls.pop_front();
				if (curve_type !== e.kind) begin
					$display("%0t: curve_type exp %0d got %0d", $time, e.kind, curve_type);
					fail_count++;
				end
				if (norm_d1 !== e.d1) begin
					$display("%0t: norm_d1 exp %0d got %0d", $time, e.d1, norm_d1);
					fail_count++;
				end
				if (norm_d2 !== e.d2) begin
					$display("%0t: norm_d2 exp %0d got %0d", $time, e.d2, norm_d2);
					fail_count++;
				end
				if (norm_d3 !== e.d3) begin
					$display("%0t: norm_d3 exp %0d got %0d", $time, e.d3, norm_d3);
					fail_count++;
				end
			end
		end
	end

	task automatic send_segment(input coord_t c[8]);
		while (int'($urandom_range(99)) < send_idle_pct) begin
			seg_valid <= 1'b0;
			@(posedge clk);
		end
		seg_valid <= 1'b1;
		p0_x <= c[0]; p0_y <= c[1]; p1_x <= c[2]; p1_y <= c[3];
		p2_x <= c[4]; p2_y <= c[5]; p3_x <= c[6]; p3_y <= c[7];
		do
			@(posedge clk);
		while (seg_stall);
		pending_cls.push_back(classify_segment(c));
	endtask

	task automatic drain;
		if (seg_valid)
			seg_valid <= 1'b0;
		while (pending_cls.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cbc_pkg::cfg_idx_t idx, input logic [15:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == cbc_pkg::CFG_ZERO_TOL)
			zero_tol = value & 16'h7fff;
		else
			point_tol = value;
	endtask

	task automatic send_pts(input int x0, y0, x1, y1, x2, y2, x3, y3);
		coord_t c[8];
		c = '{coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
			coord_t'(x2), coord_t'(y2), coord_t'(x3), coord_t'(y3)};
		send_segment(c);
	endtask

	function automatic int srange(input int lim);
		return int'($urandom_range(2 * lim)) - lim;
	endfunction

	task automatic send_random_segment;
		coord_t c[8];
		int mode, bx, by, dx, dy, qx, qy, ex, ey;
		mode = $urandom_range(99);
		if (mode < 40) begin
			for (int i = 0; i < 8; i++)
				c[i] = coord_t'($urandom);
		end else if (mode < 65) begin
			bx = srange(30000);
			by = srange(30000);
			for (int i = 0; i < 4; i++) begin
				c[2 * i] = coord_t'(bx + srange(400));
				c[2 * i + 1] = coord_t'(by + srange(400));
			end
		end else if (mode < 80) begin
			bx = srange(20000);
			by = srange(20000);
			dx = srange(200);
			dy = srange(200);
			for (int i = 0; i < 4; i++) begin
				qx = srange(50);
				c[2 * i] = coord_t'(bx + qx * dx);
				c[2 * i + 1] = coord_t'(by + qx * dy);
			end
		end else if (mode < 90) begin
			bx = srange(32000);
			by = srange(32000);
			for (int i = 0; i < 4; i++) begin
				c[2 * i] = coord_t'(bx + (i == 0 ? 0 : srange(8)));
				c[2 * i + 1] = coord_t'(by + (i == 0 ? 0 : srange(8)));
			end
		end else begin
			// degree-elevated quadratic; multiples of three keep the control points exact
			bx = 3 * srange(3000); by = 3 * srange(3000);
			qx = 3 * srange(3000); qy = 3 * srange(3000);
			ex = 3 * srange(3000); ey = 3 * srange(3000);
			c = '{coord_t'(bx), coord_t'(by),
				coord_t'((bx + 2 * qx) / 3), coord_t'((by + 2 * qy) / 3),
				coord_t'((ex + 2 * qx) / 3), coord_t'((ey + 2 * qy) / 3),
				coord_t'(ex), coord_t'(ey)};
		end
		send_segment(c);
	endtask

	task automatic test_directed;
		send_pts(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
		send_pts(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
		send_pts(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
		send_pts(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32768);
		send_pts(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
		send_pts(0, 0, 10, 10, 20, 20, 30, 30);
		send_pts(0, 0, 20, 40, 40, 40, 60, 0);
		send_pts(0, 0, 100, 100, 0, 100, 100, 0);
		send_pts(0, 0, 0, 100, 100, 100, 100, 0);
		send_pts(0, 0, 100, 100, 0, 100, 0, 0);
		send_pts(0, 0, 30, 90, 60, -90, 90, 0);
		send_pts(0, 0, 300, 0, 0, 300, 300, 300);
		send_pts(0, 0, 100, 0, 100, 100, 0, 100);
		send_pts(0, 0, 0, 0, 100, 100, 200, 0);
		send_pts(5, 5, 6, 4, 5, 6, 4, 5);
		send_pts(-1, 0, 0, 1, 1, 0, 0, -1);
		send_pts(-32768, 0, 0, 32767, 32767, 0, 0, -32768);
	endtask

	task automatic test_tolerances;
		write_reg(cbc_pkg::CFG_POINT_TOL, 16'd4);
		send_pts(5, 5, 6, 4, 5, 9, 1, 5);
		send_pts(5, 5, 6, 4, 5, 10, 1, 5);
		write_reg(cbc_pkg::CFG_ZERO_TOL, 16'd0);
		send_pts(0, 0, 1, 1, 2, 2, 30000, 30001);
		send_pts(0, 0, 100, 100, 0, 100, 100, 0);
		send_pts(0, 0, 30, 90, 60, -90, 90, 0);
		write_reg(cbc_pkg::CFG_ZERO_TOL, 16'h7fff);
		send_pts(0, 0, 100, 100, 0, 100, 100, 0);
		send_pts(-32768, -32768, 32767, -32768, -32768, 32767, 32767, 32767);
		write_reg(cbc_pkg::CFG_POINT_TOL, 16'hffff);
		send_pts(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
		write_reg(cbc_pkg::CFG_ZERO_TOL, 16'hffff);
		send_pts(0, 0, 30, 90, 60, -90, 90, 0);
		write_reg(cbc_pkg::CFG_ZERO_TOL, 16'd16);
		write_reg(cbc_pkg::CFG_POINT_TOL, 16'd0);
	endtask

	task automatic test_random(input int count, input int sidle, input int ridle);
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 99) begin
				write_reg(cbc_pkg::CFG_ZERO_TOL, 16'($urandom_range(2048)));
				write_reg(cbc_pkg::CFG_POINT_TOL, 16'($urandom_range(16)));
			end
			send_random_segment();
		end
		drain();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 17;
		recv_idle_pct = 50;
		test_directed();
		test_tolerances();
		test_random(420, 17, 50);
		test_random(420, 50, 17);
		write_reg(cbc_pkg::CFG_ZERO_TOL, 16'd16);
		write_reg(cbc_pkg::CFG_POINT_TOL, 16'd0);
		test_random(420, 0, 0);
		drain();
		repeat (LATENCY + 8) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
